>>> sv/mdo_pkg.sv
// Shared types, constants and helper functions for the mecanum odometry core.
`timescale 1ns / 1ps
package mdo_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_ENTRIES     = 24;

  localparam logic [7:0] REG_WHEEL_RADIUS   = 8'd0;
  localparam logic [7:0] REG_WHEEL_BASE_SUM = 8'd1;

  localparam logic CMD_UPDATE = 1'b0;
  localparam logic CMD_RESET  = 1'b1;

  localparam logic [15:0] RADIUS_RESET = 16'd2176;
  localparam logic [15:0] BASE_RESET   = 16'd13107;

  // Q2.30 angle constants
  localparam logic signed [34:0] TWO_PI_Q30   = 35'sd6746518852;
  localparam logic signed [34:0] PI_Q30       = 35'sd3373259426;
  localparam logic signed [34:0] HALF_PI_Q30  = 35'sd1686629713;
  localparam logic signed [33:0] CORDIC_START = 34'sd652032874;
  localparam logic [46:0] TWO_PI_WIDE   = 47'd6746518852;
  // 2*pi * 2^13, makes any shifted Q15.16 heading nonnegative
  localparam logic [46:0] REDUCE_OFFSET = 47'd55267482435584;

  typedef struct packed {
    logic               command;
    logic signed [31:0] front_right_angle;
    logic signed [31:0] front_left_angle;
    logic signed [31:0] rear_right_angle;
    logic signed [31:0] rear_left_angle;
    logic [15:0]        elapsed_time;
  } in_t;

  typedef struct packed {
    logic signed [31:0] x_velocity;
    logic signed [31:0] y_velocity;
    logic signed [31:0] angular_velocity;
    logic signed [31:0] heading;
    logic signed [31:0] x_pose;
    logic signed [31:0] y_pose;
  } out_t;

  typedef enum logic [4:0] {
    S_IDLE, S_WHEEL, S_MX, S_MY, S_MA, S_ADIV_GO, S_ADIV_WAIT, S_MH, S_HEAD,
    S_CORDIC_GO, S_CORDIC_WAIT, S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_P7, S_DONE
  } state_t;

  typedef enum logic [2:0] {
    C_IDLE, C_REDUCE, C_FOLD, C_ROTATE, C_DONE
  } cordic_state_t;

  function automatic logic signed [34:0] atan_q30(input logic [4:0] idx);
    logic signed [34:0] v;
    unique case (idx)
      5'd0:  v = 35'sd843314857;
      5'd1:  v = 35'sd497837829;
      5'd2:  v = 35'sd263043837;
      5'd3:  v = 35'sd133525159;
      5'd4:  v = 35'sd67021687;
      5'd5:  v = 35'sd33543516;
      5'd6:  v = 35'sd16775851;
      5'd7:  v = 35'sd8388437;
      5'd8:  v = 35'sd4194283;
      5'd9:  v = 35'sd2097149;
      5'd10: v = 35'sd1048576;
      5'd11: v = 35'sd524288;
      5'd12: v = 35'sd262144;
      5'd13: v = 35'sd131072;
      5'd14: v = 35'sd65536;
      5'd15: v = 35'sd32768;
      5'd16: v = 35'sd16384;
      5'd17: v = 35'sd8192;
      5'd18: v = 35'sd4096;
      5'd19: v = 35'sd2048;
      5'd20: v = 35'sd1024;
      5'd21: v = 35'sd512;
      5'd22: v = 35'sd256;
      5'd23: v = 35'sd128;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
    logic signed [31:0] r;
    if (v > 72'sd2147483647) r = 32'sh7fffffff;
    else if (v < -72'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  // saturate sign and magnitude to a signed 32-bit value
  function automatic logic signed [31:0] sat_mag(input logic [63:0] mag, input logic neg);
    logic signed [31:0] r;
    if (!neg) r = (mag > 64'd2147483647) ? 32'sh7fffffff : $signed(mag[31:0]);
    else r = (mag > 64'd2147483648) ? 32'sh80000000 : $signed(-mag[31:0]);
    return r;
  endfunction

endpackage

>>> sv/mdo_div.sv
// Unsigned restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module mdo_div #(
  parameter int NW = 48,
  parameter int DW = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo
);
  localparam int CW = $clog2(NW + 1);

  logic [DW-1:0] rem;
  logic [DW-1:0] dreg;
  logic [NW-1:0] q;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [DW:0]   trial;
  logic          ge;

  assign trial = {rem, q[NW-1]};
  assign ge    = trial >= {1'b0, dreg};
  assign quo   = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      q    <= num;
      dreg <= den;
    end else if (busy) begin
      rem <= ge ? DW'(trial - {1'b0, dreg}) : trial[DW-1:0];
      q   <= {q[NW-2:0], ge};
    end
  end
endmodule

>>> sv/mdo_lane.sv
// One wheel lane: stored angle, wrapped difference and rate division.
`timescale 1ns / 1ps
module mdo_lane (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               clear,
  input  logic signed [31:0] angle,
  input  logic [15:0]        dt,
  output logic               done,
  output logic signed [31:0] rate
);
  logic [31:0] prev;
  logic [31:0] diff;
  logic [31:0] mag;
  logic        neg;
  logic [47:0] q;

  assign diff = angle - prev;
  assign mag  = diff[31] ? (~diff + 32'd1) : diff;

  always_ff @(posedge clk) begin
    if (rst || clear) prev <= '0;
    else if (start) prev <= angle;
  end

  always_ff @(posedge clk) begin
    if (start) neg <= diff[31];
  end

  mdo_div #(.NW(48), .DW(16)) u_div (
    .clk(clk), .rst(rst), .start(start), .num({mag, 16'd0}), .den(dt),
    .done(done), .quo(q)
  );

  assign rate = mdo_pkg::sat_mag({16'd0, q}, neg);
endmodule

>>> sv/mdo_cordic.sv
// Angle reduction and iterative CORDIC rotation for sine and cosine.
`timescale 1ns / 1ps
module mdo_cordic #(
  parameter int STEPS = mdo_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] angle,
  output logic               done,
  output logic signed [33:0] cos_val,
  output logic signed [33:0] sin_val
);
  localparam int NSTEP = (STEPS > mdo_pkg::ATAN_ENTRIES) ? mdo_pkg::ATAN_ENTRIES : STEPS;

  mdo_pkg::cordic_state_t state, state_next;
  logic [46:0]        rem;
  logic [46:0]        sub;
  logic [3:0]         k;
  logic [4:0]         i;
  logic signed [34:0] z, r0, r1, r2;
  logic               fold_neg, neg;
  logic signed [33:0] x, y, xs, ys;

  assign sub = mdo_pkg::TWO_PI_WIDE << k;

  always_comb begin
    r0 = $signed({2'b00, rem[32:0]});
    r1 = (r0 > mdo_pkg::PI_Q30) ? r0 - mdo_pkg::TWO_PI_Q30 : r0;
    fold_neg = 1'b1;
    if (r1 > mdo_pkg::HALF_PI_Q30) r2 = r1 - mdo_pkg::PI_Q30;
    else if (r1 < -mdo_pkg::HALF_PI_Q30) r2 = r1 + mdo_pkg::PI_Q30;
    else begin
      r2 = r1;
      fold_neg = 1'b0;
    end
  end

  assign xs = x >>> i;
  assign ys = y >>> i;

  always_comb begin
    state_next = state;
    unique case (state)
      mdo_pkg::C_IDLE:   if (start) state_next = mdo_pkg::C_REDUCE;
      mdo_pkg::C_REDUCE: if (k == 4'd0) state_next = mdo_pkg::C_FOLD;
      mdo_pkg::C_FOLD:   state_next = mdo_pkg::C_ROTATE;
      mdo_pkg::C_ROTATE: if (i == 5'(NSTEP - 1)) state_next = mdo_pkg::C_DONE;
      mdo_pkg::C_DONE:   state_next = mdo_pkg::C_IDLE;
      default:           state_next = mdo_pkg::C_IDLE;
    endcase
  end

  always_comb begin
    done    = (state == mdo_pkg::C_DONE);
    cos_val = neg ? -x : x;
    sin_val = neg ? -y : y;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= mdo_pkg::C_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    unique case (state)
      mdo_pkg::C_IDLE: begin
        rem <= 47'($signed({{15{angle[31]}}, angle}) <<< 14) + mdo_pkg::REDUCE_OFFSET;
        k   <= 4'd13;
      end
      mdo_pkg::C_REDUCE: begin
        if (rem >= sub) rem <= rem - sub;
        k <= k - 4'd1;
      end
      mdo_pkg::C_FOLD: begin
        z   <= r2;
        neg <= fold_neg;
        x   <= mdo_pkg::CORDIC_START;
        y   <= '0;
        i   <= '0;
      end
      mdo_pkg::C_ROTATE: begin
        if (!z[34]) begin
          x <= x - ys;
          y <= y + xs;
          z <= z - mdo_pkg::atan_q30(i);
        end else begin
          x <= x + ys;
          y <= y - xs;
          z <= z + mdo_pkg::atan_q30(i);
        end
        i <= i + 5'd1;
      end
      default: ;
    endcase
  end
endmodule

>>> sv/mecanum_drive_odometry_core.sv
// Mecanum odometry top level: four wheel lanes, merging sequencer, CORDIC, pose update.
// The 48-bit wheel rate division and the 50-bit yaw division dominate the time from accepted
// request to valid result. One request is taken at a time: in_ready is high only in S_IDLE,
// and the core waits in S_DONE until the previous result is taken. A reset command skips the
// update steps and goes straight to S_DONE.
// Reset (rst, synchronous): registers to default values, pose, heading and angles to zero.
`timescale 1ns / 1ps
module mecanum_drive_odometry_core #(
  parameter int CORDIC_STEPS = mdo_pkg::CORDIC_STEPS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  mdo_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output mdo_pkg::out_t out_data,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [7:0]    cfg_index,
  input  logic [15:0]   cfg_data
);
  mdo_pkg::state_t state, state_next;

  logic [15:0] radius, base;
  logic [15:0] dt;
  logic        accept, do_update, lane_clear;
  logic [3:0]  lane_done;
  logic signed [31:0] rate [4];
  logic signed [31:0] rate_q [4];
  logic signed [31:0] lane_angle [4];
  logic signed [35:0] sx, sy, sa;
  logic signed [31:0] vx, vy, va, heading, xpos, ypos;
  logic signed [35:0] mul_a, mul_b, dx;
  logic signed [71:0] prod, t, sum_sub, sum_add;
  logic [71:0]  prod_mag;
  logic         a_neg, div_start, div_done, cordic_start, cordic_done, load_out;
  logic [49:0]  a_quo;
  logic [17:0]  a_den;
  logic signed [33:0] cos_v, sin_v, cos_q, sin_q;

  assign accept    = in_valid && in_ready;
  assign do_update = accept && (in_data.command == mdo_pkg::CMD_UPDATE);
  assign lane_clear = accept && (in_data.command == mdo_pkg::CMD_RESET);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= mdo_pkg::RADIUS_RESET;
      base   <= mdo_pkg::BASE_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == mdo_pkg::REG_WHEEL_RADIUS) radius <= cfg_data;
      else if (cfg_index == mdo_pkg::REG_WHEEL_BASE_SUM) base <= cfg_data;
    end
  end

  assign lane_angle[0] = in_data.front_right_angle;
  assign lane_angle[1] = in_data.front_left_angle;
  assign lane_angle[2] = in_data.rear_right_angle;
  assign lane_angle[3] = in_data.rear_left_angle;

  for (genvar g = 0; g < 4; g++) begin : g_lane
    mdo_lane u_lane (
      .clk(clk), .rst(rst), .start(do_update), .clear(lane_clear),
      .angle(lane_angle[g]),
      .dt((in_data.elapsed_time == 16'd0) ? 16'd1 : in_data.elapsed_time),
      .done(lane_done[g]), .rate(rate[g])
    );
  end

  // order: FR, FL, RR, RL
  assign sx = 36'(rate_q[0]) + 36'(rate_q[1]) + 36'(rate_q[2]) + 36'(rate_q[3]);
  assign sy = 36'(rate_q[0]) - 36'(rate_q[1]) + 36'(rate_q[3]) - 36'(rate_q[2]);
  assign sa = 36'(rate_q[0]) - 36'(rate_q[1]) - 36'(rate_q[3]) + 36'(rate_q[2]);

  assign prod_mag = prod[71] ? 72'(-prod) : 72'(prod);
  assign a_den    = {((base == 16'd0) ? 16'd1 : base), 2'b00};

  mdo_div #(.NW(50), .DW(18)) u_adiv (
    .clk(clk), .rst(rst), .start(div_start), .num(prod_mag[49:0]), .den(a_den),
    .done(div_done), .quo(a_quo)
  );

  mdo_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk(clk), .rst(rst), .start(cordic_start), .angle(heading),
    .done(cordic_done), .cos_val(cos_v), .sin_val(sin_v)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      mdo_pkg::S_IDLE: begin
        if (do_update) state_next = mdo_pkg::S_WHEEL;
        else if (lane_clear) state_next = mdo_pkg::S_DONE;
      end
      mdo_pkg::S_WHEEL:       if (lane_done[0]) state_next = mdo_pkg::S_MX;
      mdo_pkg::S_MX:          state_next = mdo_pkg::S_MY;
      mdo_pkg::S_MY:          state_next = mdo_pkg::S_MA;
      mdo_pkg::S_MA:          state_next = mdo_pkg::S_ADIV_GO;
      mdo_pkg::S_ADIV_GO:     state_next = mdo_pkg::S_ADIV_WAIT;
      mdo_pkg::S_ADIV_WAIT:   if (div_done) state_next = mdo_pkg::S_MH;
      mdo_pkg::S_MH:          state_next = mdo_pkg::S_HEAD;
      mdo_pkg::S_HEAD:        state_next = mdo_pkg::S_CORDIC_GO;
      mdo_pkg::S_CORDIC_GO:   state_next = mdo_pkg::S_CORDIC_WAIT;
      mdo_pkg::S_CORDIC_WAIT: if (cordic_done) state_next = mdo_pkg::S_P1;
      mdo_pkg::S_P1:          state_next = mdo_pkg::S_P2;
      mdo_pkg::S_P2:          state_next = mdo_pkg::S_P3;
      mdo_pkg::S_P3:          state_next = mdo_pkg::S_P4;
      mdo_pkg::S_P4:          state_next = mdo_pkg::S_P5;
      mdo_pkg::S_P5:          state_next = mdo_pkg::S_P6;
      mdo_pkg::S_P6:          state_next = mdo_pkg::S_P7;
      mdo_pkg::S_P7:          state_next = mdo_pkg::S_DONE;
      mdo_pkg::S_DONE:        if (!out_valid || out_ready) state_next = mdo_pkg::S_IDLE;
      default:                state_next = mdo_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = (state == mdo_pkg::S_IDLE);
    div_start    = (state == mdo_pkg::S_ADIV_GO);
    cordic_start = (state == mdo_pkg::S_CORDIC_GO);
    load_out     = (state == mdo_pkg::S_DONE) && (!out_valid || out_ready);
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      mdo_pkg::S_MX: begin mul_a = sx; mul_b = {20'd0, radius}; end
      mdo_pkg::S_MY: begin mul_a = sy; mul_b = {20'd0, radius}; end
      mdo_pkg::S_MA: begin mul_a = sa; mul_b = {20'd0, radius}; end
      mdo_pkg::S_MH: begin mul_a = 36'(va); mul_b = {20'd0, dt}; end
      mdo_pkg::S_P1: begin mul_a = 36'(vx); mul_b = 36'(cos_q); end
      mdo_pkg::S_P2: begin mul_a = 36'(vy); mul_b = 36'(sin_q); end
      mdo_pkg::S_P3: begin mul_a = 36'(vx); mul_b = 36'(sin_q); end
      mdo_pkg::S_P4: begin mul_a = 36'(vy); mul_b = 36'(cos_q); end
      mdo_pkg::S_P5: begin mul_a = dx; mul_b = {20'd0, dt}; end
      mdo_pkg::S_P6: begin mul_a = 36'(t >>> 30); mul_b = {20'd0, dt}; end
      default: ;
    endcase
  end

  assign sum_sub = t - prod;
  assign sum_add = t + prod;

  always_ff @(posedge clk) begin
    if (rst) state <= mdo_pkg::S_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (load_out) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      heading <= '0;
      xpos    <= '0;
      ypos    <= '0;
    end else begin
      if (lane_clear) begin
        heading <= '0;
        xpos    <= '0;
        ypos    <= '0;
      end
      if (state == mdo_pkg::S_HEAD) heading <= mdo_pkg::sat32(72'(heading) + (prod >>> 15));
      if (state == mdo_pkg::S_P6) xpos <= mdo_pkg::sat32(72'(xpos) + (prod >>> 16));
      if (state == mdo_pkg::S_P7) ypos <= mdo_pkg::sat32(72'(ypos) + (prod >>> 16));
    end
  end

  always_ff @(posedge clk) begin
    if (do_update) dt <= (in_data.elapsed_time == 16'd0) ? 16'd1 : in_data.elapsed_time;
    if (lane_clear) begin
      vx <= '0;
      vy <= '0;
      va <= '0;
    end
    if (state == mdo_pkg::S_WHEEL && lane_done[0]) begin
      for (int n = 0; n < 4; n++) rate_q[n] <= rate[n];
    end
    if (state == mdo_pkg::S_MY) vx <= mdo_pkg::sat32(prod >>> 18);
    if (state == mdo_pkg::S_MA) vy <= mdo_pkg::sat32(prod >>> 18);
    if (state == mdo_pkg::S_ADIV_GO) a_neg <= prod[71];
    if (state == mdo_pkg::S_ADIV_WAIT && div_done) va <= mdo_pkg::sat_mag(64'(a_quo), a_neg);
    if (state == mdo_pkg::S_CORDIC_WAIT && cordic_done) begin
      cos_q <= cos_v;
      sin_q <= sin_v;
    end
    if (state == mdo_pkg::S_P2) t <= prod;
    if (state == mdo_pkg::S_P3) dx <= 36'(sum_sub >>> 30);
    if (state == mdo_pkg::S_P4) t <= prod;
    // keep dy as the 72-bit sum; S_P6 takes it shifted
    if (state == mdo_pkg::S_P5) t <= sum_add;
    if (load_out) begin
      out_data.x_velocity       <= vx;
      out_data.y_velocity       <= vy;
      out_data.angular_velocity <= va;
      out_data.heading          <= heading;
      out_data.x_pose           <= xpos;
      out_data.y_pose           <= ypos;
    end
  end
endmodule
